>>> hdl/gsa_pkg.sv
// Shared types and constants for the generational slot allocator.
`default_nettype none

package gsa_pkg;

    // Table geometry, fixed by the handle format
    localparam int SLOT_COUNT = 256;
    localparam int IDX_BITS   = 8;
    localparam int CNT_BITS   = 9;
    localparam int GEN_BITS   = 16;

    localparam logic [GEN_BITS-1:0] GEN_ZERO = '0;
    localparam logic [GEN_BITS-1:0] GEN_ONE  = {{(GEN_BITS-1){1'b0}}, 1'b1};
    localparam logic [CNT_BITS-1:0] CNT_ONE  = {{(CNT_BITS-1){1'b0}}, 1'b1};
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(SLOT_COUNT);

    // Request modes
    localparam logic [1:0] MODE_ALLOC   = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_CHECK   = 2'd2;

    // Response status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    // Request word
    typedef struct packed {
        logic [1:0]          mode;
        logic [IDX_BITS-1:0] slot_index;
        logic [GEN_BITS-1:0] handle_generation;
    } req_word_t;

    // Response word
    typedef struct packed {
        logic [1:0]          status;
        logic [IDX_BITS-1:0] granted_index;
        logic [GEN_BITS-1:0] granted_generation;
    } rsp_word_t;

    // One slot table entry
    typedef struct packed {
        logic                active;
        logic [GEN_BITS-1:0] gen;
    } slot_entry_t;

    // Free queue control from the sequencer
    typedef struct packed {
        logic                rd_en;
        logic                pop;
        logic                push;
        logic [IDX_BITS-1:0] push_slot;
    } fifo_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/gsa_free_fifo.sv
// FIFO of released slot numbers, held in a synchronous memory.
`default_nettype none

module gsa_free_fifo (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire gsa_pkg::fifo_ctrl_t           ctrl,
    output logic [gsa_pkg::IDX_BITS-1:0]       head_slot,
    output logic                               empty
);

    logic [gsa_pkg::IDX_BITS-1:0] queue_mem [gsa_pkg::SLOT_COUNT];
    logic [gsa_pkg::IDX_BITS-1:0] q_reg;
    logic [gsa_pkg::IDX_BITS-1:0] head_reg;
    logic [gsa_pkg::IDX_BITS-1:0] head_next;
    logic [gsa_pkg::IDX_BITS-1:0] tail_reg;
    logic [gsa_pkg::IDX_BITS-1:0] tail_next;
    logic [gsa_pkg::CNT_BITS-1:0] count_reg;
    logic [gsa_pkg::CNT_BITS-1:0] count_next;

    // Pointer and count update; pointers wrap with the table size
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctrl.pop)
        begin
            head_next  = head_reg + 1'b1;
            count_next = count_reg - gsa_pkg::CNT_ONE;
        end
        if (ctrl.push)
        begin
            tail_next  = tail_reg + 1'b1;
            count_next = count_reg + gsa_pkg::CNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Queue memory: write at tail, registered read at head
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            queue_mem[tail_reg] <= ctrl.push_slot;
        end
        if (ctrl.rd_en)
        begin
            q_reg <= queue_mem[head_reg];
        end
    end

    assign head_slot = q_reg;
    assign empty     = (count_reg == '0);

endmodule

`default_nettype wire

>>> hdl/generational_slot_allocator.sv
// Top level: generational handle allocator with slot table and free queue.
//
//  channel | valid     | stall     | word
//  --------+-----------+-----------+---------------------------------------------
//  request | req_valid | req_stall | req: mode, slot_index, handle_generation
//  result  | rsp_valid | rsp_stall | rsp: status, granted_index, granted_generation
//
// One request at a time: 2 cycles per request (accept with slot table read,
// evaluate), 3 for an allocate that reuses a queued slot, since the slot table
// must be read again at the slot number coming out of the free queue.
// Reset clears the pointers, counts and handshake state; table entries at or
// above the used mark are never read, so the memories need no clearing.
// A stalled result holds in the output register and holds back the next finish.
`default_nettype none

module generational_slot_allocator (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_stall,
    input  wire gsa_pkg::req_word_t   req,
    output logic                      rsp_valid,
    input  wire logic                 rsp_stall,
    output gsa_pkg::rsp_word_t        rsp
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EVAL  = 2'd1;
    localparam logic [1:0] ST_REUSE = 2'd2;

    logic [1:0]                   state_reg;
    logic [1:0]                   state_next;
    gsa_pkg::req_word_t           req_reg;
    logic [gsa_pkg::CNT_BITS-1:0] mark_reg;
    logic [gsa_pkg::CNT_BITS-1:0] mark_next;
    logic                         rsp_valid_reg;
    logic                         rsp_valid_next;
    gsa_pkg::rsp_word_t           rsp_reg;
    gsa_pkg::rsp_word_t           rsp_next;

    gsa_pkg::slot_entry_t         slot_mem [gsa_pkg::SLOT_COUNT];
    gsa_pkg::slot_entry_t         slot_rdata_reg;
    logic                         slot_rd_en;
    logic [gsa_pkg::IDX_BITS-1:0] slot_rd_addr;
    logic                         slot_we;
    logic [gsa_pkg::IDX_BITS-1:0] slot_wr_addr;
    gsa_pkg::slot_entry_t         slot_wdata;

    gsa_pkg::fifo_ctrl_t          fifo_ctrl;
    logic [gsa_pkg::IDX_BITS-1:0] fifo_slot;
    logic                         fifo_empty;

    logic                         req_fire;
    logic                         out_free;
    logic                         handle_hit;

    gsa_free_fifo u_free_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (fifo_ctrl),
        .head_slot (fifo_slot),
        .empty     (fifo_empty)
    );

    assign req_stall = (state_reg != ST_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    // Handle is live: inside the used range, active, same generation
    assign handle_hit = ({1'b0, req_reg.slot_index} < mark_reg)
                        && slot_rdata_reg.active
                        && (slot_rdata_reg.gen == req_reg.handle_generation);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        mark_next      = mark_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        slot_rd_en     = req_fire;
        slot_rd_addr   = req.slot_index;
        slot_we        = 1'b0;
        slot_wr_addr   = req_reg.slot_index;
        slot_wdata     = slot_rdata_reg;
        fifo_ctrl      = '{rd_en: req_fire, pop: 1'b0, push: 1'b0,
                           push_slot: req_reg.slot_index};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if ((req_reg.mode == gsa_pkg::MODE_ALLOC) && !fifo_empty)
                begin
                    // read the generation of the queued slot
                    slot_rd_en   = 1'b1;
                    slot_rd_addr = fifo_slot;
                    state_next   = ST_REUSE;
                end
                else if (out_free)
                begin
                    state_next         = ST_IDLE;
                    rsp_valid_next     = 1'b1;
                    rsp_next.status             = gsa_pkg::STATUS_INVALID;
                    rsp_next.granted_index      = req_reg.slot_index;
                    rsp_next.granted_generation = gsa_pkg::GEN_ZERO;
                    priority if (req_reg.mode == gsa_pkg::MODE_ALLOC)
                    begin
                        if (mark_reg == gsa_pkg::CNT_FULL)
                        begin
                            rsp_next.status = gsa_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            // fresh slot at the used mark, generation zero
                            slot_we      = 1'b1;
                            slot_wr_addr = mark_reg[gsa_pkg::IDX_BITS-1:0];
                            slot_wdata   = '{active: 1'b1, gen: gsa_pkg::GEN_ZERO};
                            mark_next    = mark_reg + gsa_pkg::CNT_ONE;
                            rsp_next.status        = gsa_pkg::STATUS_OK;
                            rsp_next.granted_index = mark_reg[gsa_pkg::IDX_BITS-1:0];
                        end
                    end
                    else if (req_reg.mode == gsa_pkg::MODE_RELEASE)
                    begin
                        if (handle_hit)
                        begin
                            slot_we        = 1'b1;
                            slot_wdata     = '{active: 1'b0,
                                               gen: slot_rdata_reg.gen + gsa_pkg::GEN_ONE};
                            fifo_ctrl.push = 1'b1;
                            rsp_next.status = gsa_pkg::STATUS_OK;
                        end
                    end
                    else if (req_reg.mode == gsa_pkg::MODE_CHECK)
                    begin
                        if (handle_hit)
                        begin
                            rsp_next.status = gsa_pkg::STATUS_OK;
                        end
                    end
                    else
                    begin
                        rsp_next.status = gsa_pkg::STATUS_INVALID;
                    end
                end
            end
            ST_REUSE:
            begin
                if (out_free)
                begin
                    // reactivate the queued slot, keep its generation
                    state_next    = ST_IDLE;
                    slot_we       = 1'b1;
                    slot_wr_addr  = fifo_slot;
                    slot_wdata    = '{active: 1'b1, gen: slot_rdata_reg.gen};
                    fifo_ctrl.pop = 1'b1;
                    rsp_valid_next = 1'b1;
                    rsp_next.status             = gsa_pkg::STATUS_OK;
                    rsp_next.granted_index      = fifo_slot;
                    rsp_next.granted_generation = slot_rdata_reg.gen;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mark_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mark_reg      <= mark_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            req_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    // Slot table memory with registered read
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_wr_addr] <= slot_wdata;
        end
        if (slot_rd_en)
        begin
            slot_rdata_reg <= slot_mem[slot_rd_addr];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire
